FILE: src/rkc_pkg.sv
// ----------------------------------------------------------------------------
// rkc_pkg
// Shared widths, register map, reset values and types of the 3x3 RGB
// convolution block.
// ----------------------------------------------------------------------------
package rkc_pkg;

    localparam int SAMPLE_W     = 8;
    localparam int PIXEL_W      = 3 * SAMPLE_W;
    localparam int COEF_W       = 16;
    localparam int LINE_WIDTH_W = 11;
    localparam int LINE_COUNT_W = 16;
    localparam int ROW_W        = LINE_COUNT_W + 1;     // counts up to line_count + 1
    localparam int COEF_ROW_W   = 3 * COEF_W;
    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 6;
    localparam int PROD_W       = SAMPLE_W + 1 + COEF_W;
    localparam int TERM_W       = PROD_W - 8;           // product after dropping Q8 fraction
    localparam int ACC_W        = TERM_W + 3;           // nine terms

    // register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_LINE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_LINE_COUNT  = 3'd1;
    localparam logic [2:0] REG_COEF_TOP    = 3'd2;
    localparam logic [2:0] REG_COEF_MIDDLE = 3'd3;
    localparam logic [2:0] REG_COEF_BOTTOM = 3'd4;

    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST  = 11'd1024;
    localparam logic [LINE_COUNT_W-1:0] LINE_COUNT_RST  = 16'd1;
    localparam logic [COEF_ROW_W-1:0]   COEF_TOP_RST    = 48'h0000_0000_0000;
    localparam logic [COEF_ROW_W-1:0]   COEF_MIDDLE_RST = 48'h0000_0100_0000;
    localparam logic [COEF_ROW_W-1:0]   COEF_BOTTOM_RST = 48'h0000_0000_0000;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [COEF_W-1:0]  coef_t;

    // [row][col]: row 0 is the line above, col 0 the leftmost tap
    typedef coef_t  [2:0][2:0] coef_grid_t;
    typedef pixel_t [2:0][2:0] tap_grid_t;
    typedef logic   [2:0][2:0] tap_mask_t;

    typedef struct packed {
        logic [LINE_COUNT_W-1:0] count;
        logic [LINE_COUNT_W-1:0] count_last;
        logic                    restart;
        coef_grid_t              coef;
    } frame_cfg_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_pair_t;

endpackage

FILE: src/rkc_if.sv
// ----------------------------------------------------------------------------
// rkc_if
// Valid/ready stream channels: incoming pixels and filtered results.
// ----------------------------------------------------------------------------
interface rkc_pix_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, kind, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface rkc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_of_frame;

    modport source (output valid, red_out, green_out, blue_out, last_of_frame, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, last_of_frame, output ready);
endinterface

FILE: src/rkc_apb_regs.sv
// ----------------------------------------------------------------------------
// rkc_apb_regs
// APB register file: frame size and kernel rows, with the effective
// (clamped) frame size handed to the datapath.
// ----------------------------------------------------------------------------
module rkc_apb_regs
    import rkc_pkg::*;
#(
    parameter int MAX_LINE = 1024,
    localparam int AW = $clog2(MAX_LINE)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output frame_cfg_t            cfg,
    output logic [AW-1:0]         width_last
);

    logic [LINE_WIDTH_W-1:0] line_width_reg;
    logic [LINE_COUNT_W-1:0] line_count_reg;
    logic [COEF_ROW_W-1:0]   coef_top_reg;
    logic [COEF_ROW_W-1:0]   coef_middle_reg;
    logic [COEF_ROW_W-1:0]   coef_bottom_reg;
    logic [2:0]              reg_idx;
    logic                    wr_fire;

    assign reg_idx = paddr[APB_ADDR_W-1:3];
    assign wr_fire = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= LINE_WIDTH_RST;
            line_count_reg  <= LINE_COUNT_RST;
            coef_top_reg    <= COEF_TOP_RST;
            coef_middle_reg <= COEF_MIDDLE_RST;
            coef_bottom_reg <= COEF_BOTTOM_RST;
        end
        else if (wr_fire)
        begin
            case (reg_idx)
                REG_LINE_WIDTH:  line_width_reg  <= pwdata[LINE_WIDTH_W-1:0];
                REG_LINE_COUNT:  line_count_reg  <= pwdata[LINE_COUNT_W-1:0];
                REG_COEF_TOP:    coef_top_reg    <= pwdata[COEF_ROW_W-1:0];
                REG_COEF_MIDDLE: coef_middle_reg <= pwdata[COEF_ROW_W-1:0];
                REG_COEF_BOTTOM: coef_bottom_reg <= pwdata[COEF_ROW_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_LINE_WIDTH:  prdata = APB_DATA_W'(line_width_reg);
            REG_LINE_COUNT:  prdata = APB_DATA_W'(line_count_reg);
            REG_COEF_TOP:    prdata = APB_DATA_W'(coef_top_reg);
            REG_COEF_MIDDLE: prdata = APB_DATA_W'(coef_middle_reg);
            REG_COEF_BOTTOM: prdata = APB_DATA_W'(coef_bottom_reg);
            default:         prdata = '0;
        endcase
    end

    // width 0 behaves as 1, anything above the line store depth as the depth
    always_comb
    begin
        if (line_width_reg == '0)
            width_last = '0;
        else if (32'(line_width_reg) > MAX_LINE)
            width_last = AW'(MAX_LINE - 1);
        else
            width_last = AW'(line_width_reg - 11'd1);
    end

    always_comb
    begin
        cfg.count      = (line_count_reg == '0) ? 16'd1 : line_count_reg;
        cfg.count_last = cfg.count - 16'd1;
        cfg.restart    = wr_fire && (reg_idx == REG_LINE_WIDTH || reg_idx == REG_LINE_COUNT);
        for (int c = 0; c < 3; c++)
        begin
            cfg.coef[0][c] = coef_top_reg[COEF_W*c +: COEF_W];
            cfg.coef[1][c] = coef_middle_reg[COEF_W*c +: COEF_W];
            cfg.coef[2][c] = coef_bottom_reg[COEF_W*c +: COEF_W];
        end
    end

endmodule

FILE: src/rkc_line_store.sv
// ----------------------------------------------------------------------------
// rkc_line_store
// Two previous lines held side by side in one memory, registered read,
// write-to-read forwarding for a one-pixel line.
// ----------------------------------------------------------------------------
module rkc_line_store
    import rkc_pkg::*;
#(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  line_pair_t    wr_data,
    output line_pair_t    rd_data
);

    line_pair_t store_mem [DEPTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
    end

    // same address on both ports only happens when the line is one pixel wide
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= wr_data;
            else
                rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/rkc_conv.sv
// ----------------------------------------------------------------------------
// rkc_conv
// Weighs the 3x3 window with the Q8.8 kernel per colour channel, rounds
// each product toward zero, sums and clamps to 0..255.
// ----------------------------------------------------------------------------
module rkc_conv
    import rkc_pkg::*;
(
    input  tap_grid_t  taps,
    input  tap_mask_t  mask,
    input  coef_grid_t coef,
    output pixel_t     result
);

    always_comb
    begin
        logic        [SAMPLE_W-1:0] smp;
        logic signed [PROD_W-1:0]   prod;
        logic signed [PROD_W-1:0]   biased;
        logic signed [ACC_W-1:0]    acc;

        result = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    smp    = mask[r][c] ? taps[r][c][SAMPLE_W*ch +: SAMPLE_W] : '0;
                    prod   = $signed({1'b0, smp}) * $signed(coef[r][c]);
                    // bias negatives so the shift truncates toward zero
                    biased = prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
                    acc    = acc + {{(ACC_W-TERM_W){biased[PROD_W-1]}},
                                    biased[PROD_W-1 -: TERM_W]};
                end
            end
            if (acc[ACC_W-1])
                result[SAMPLE_W*ch +: SAMPLE_W] = '0;
            else if (acc[ACC_W-2:SAMPLE_W] != '0)
                result[SAMPLE_W*ch +: SAMPLE_W] = '1;
            else
                result[SAMPLE_W*ch +: SAMPLE_W] = acc[SAMPLE_W-1:0];
        end
    end

endmodule

FILE: src/rgb_kernel_convolution_3x3.sv
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_3x3
// 3x3 kernel over an RGB raster stream, zero outside the frame, Q8.8
// coefficients, results clamped to 0..255.
//
//   port        dir   kind          carries
//   pixel       in    valid/ready   kind, red_in, green_in, blue_in
//   result      out   valid/ready   red_out, green_out, blue_out, last_of_frame
//   psel..      in    APB           frame size and kernel rows (8-byte stride)
//
// One pixel per clock while results are taken. Pipeline: line store read
// into the input stage, then window, kernel and clamp into the result
// register; a result leaves the result register one line plus one pixel
// behind the pixel stream. Line stores are not cleared after reset: taps
// that would read unwritten entries lie outside the frame and are masked.
// A stalled result holds the input stage; an empty input stage still takes
// a pixel.
// ----------------------------------------------------------------------------
module rgb_kernel_convolution_3x3
    import rkc_pkg::*;
#(
    parameter int MAX_LINE    = 1024,
    parameter int KERNEL_SIZE = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    rkc_pix_if.sink               pixel,
    rkc_res_if.source             result
);

    localparam int AW       = $clog2(MAX_LINE);
    localparam bit HAS_RING = ((KERNEL_SIZE - 1) / 2) > 0;

    frame_cfg_t    cfg;
    logic [AW-1:0] w_last;

    // stream and output positions
    logic [AW-1:0]           col_reg,  col_next;
    logic [ROW_W-1:0]        row_reg,  row_next;
    logic [AW-1:0]           ocol_reg, ocol_next;
    logic [LINE_COUNT_W-1:0] orow_reg, orow_next;

    // item entering
    logic    accept;
    logic    s0_pix_ok;
    logic    s0_emit;
    logic    s0_last;
    border_t s0_border;
    pixel_t  s0_sample;

    // input stage
    logic          a_valid_reg;
    logic          a_emit_reg;
    logic          a_last_reg;
    border_t       a_border_reg;
    pixel_t        a_sample_reg;
    logic [AW-1:0] a_addr_reg;
    logic          a_go;
    logic          adv;

    line_pair_t rd_pair;
    line_pair_t wr_pair;
    tap_grid_t  taps_reg;
    tap_grid_t  taps_shift;
    tap_mask_t  tap_mask;
    logic [2:0] row_en;
    logic [2:0] col_en;
    pixel_t     conv_pix;

    // result register
    logic   out_valid_reg;
    pixel_t out_pix_reg;
    logic   out_last_reg;

    rkc_apb_regs #(
        .MAX_LINE (MAX_LINE)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .width_last (w_last)
    );

    assign adv          = !out_valid_reg || result.ready;
    assign a_go         = a_valid_reg && adv;
    assign pixel.ready  = !a_valid_reg || adv;
    assign accept       = pixel.valid && pixel.ready;

    assign s0_pix_ok = !pixel.kind && (row_reg < {1'b0, cfg.count});
    assign s0_sample = s0_pix_ok ? {pixel.blue_in, pixel.green_in, pixel.red_in} : '0;
    // first result once a line and one pixel are in
    assign s0_emit   = (row_reg > ROW_W'(1)) || ((row_reg == ROW_W'(1)) && (col_reg != '0));
    assign s0_last   = (orow_reg == cfg.count_last) && (ocol_reg == w_last);

    assign s0_border.top    = (orow_reg != '0);
    assign s0_border.bottom = (orow_reg != cfg.count_last);
    assign s0_border.left   = (ocol_reg != '0);
    assign s0_border.right  = (ocol_reg != w_last);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (cfg.restart)
        begin
            col_next  = '0;
            row_next  = '0;
            ocol_next = '0;
            orow_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == w_last)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
                col_next = col_reg + 1'b1;

            if (s0_emit)
            begin
                if (ocol_reg == w_last)
                begin
                    ocol_next = '0;
                    orow_next = orow_reg + 1'b1;
                end
                else
                    ocol_next = ocol_reg + 1'b1;
            end

            // frame done: next item starts a new one
            if (s0_emit && s0_last)
            begin
                col_next  = '0;
                row_next  = '0;
                ocol_next = '0;
                orow_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (accept)
            a_valid_reg <= 1'b1;
        else if (a_go)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_emit_reg   <= s0_emit;
            a_last_reg   <= s0_emit && s0_last;
            a_border_reg <= s0_border;
            a_sample_reg <= s0_sample;
            a_addr_reg   <= col_reg;
        end
    end

    // the upper line takes the old middle entry, the middle takes this pixel
    assign wr_pair.upper  = rd_pair.middle;
    assign wr_pair.middle = a_sample_reg;

    rkc_line_store #(
        .DEPTH (MAX_LINE)
    ) u_lines (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (a_go),
        .wr_addr (a_addr_reg),
        .wr_data (wr_pair),
        .rd_data (rd_pair)
    );

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            taps_shift[r][0] = taps_reg[r][1];
            taps_shift[r][1] = taps_reg[r][2];
        end
        taps_shift[0][2] = rd_pair.upper;
        taps_shift[1][2] = rd_pair.middle;
        taps_shift[2][2] = a_sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            taps_reg <= '0;
        else if (cfg.restart)
            taps_reg <= '0;
        else if (a_go)
            taps_reg <= a_last_reg ? '0 : taps_shift;
    end

    assign row_en = {a_border_reg.bottom && HAS_RING, 1'b1, a_border_reg.top && HAS_RING};
    assign col_en = {a_border_reg.right && HAS_RING, 1'b1, a_border_reg.left && HAS_RING};

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
                tap_mask[r][c] = row_en[r] && col_en[c];
        end
    end

    rkc_conv u_conv (
        .taps   (taps_shift),
        .mask   (tap_mask),
        .coef   (cfg.coef),
        .result (conv_pix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (a_go && a_emit_reg)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_go && a_emit_reg)
        begin
            out_pix_reg  <= conv_pix;
            out_last_reg <= a_last_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.red_out       = out_pix_reg[SAMPLE_W-1:0];
    assign result.green_out     = out_pix_reg[2*SAMPLE_W-1:SAMPLE_W];
    assign result.blue_out      = out_pix_reg[3*SAMPLE_W-1:2*SAMPLE_W];
    assign result.last_of_frame = out_last_reg;

    // positions never run past the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= w_last) && (ocol_reg <= w_last))
        else $error("column position beyond line width");

    assert property (@(posedge clk) disable iff (!rst_n)
        orow_reg <= cfg.count_last)
        else $error("output row beyond frame");

    // no result before the first line is in
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s0_emit |-> row_reg != '0)
        else $error("result scheduled during first line");

    // frame end restarts the stream position
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s0_emit && s0_last && !cfg.restart |=> (col_reg == '0) && (row_reg == '0))
        else $error("frame end did not restart position");

    // a held input stage keeps its line store address
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !adv |=> a_valid_reg && $stable(a_addr_reg))
        else $error("input stage lost while stalled");

endmodule
